/* src/tcsf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tcsf_pkg;

	// TCP flag bits, as they appear in the flag byte
	localparam logic [7:0] FLAG_FIN = 8'h01;
	localparam logic [7:0] FLAG_SYN = 8'h02;
	localparam logic [7:0] FLAG_RST = 8'h04;
	localparam logic [7:0] FLAG_PSH = 8'h08;
	localparam logic [7:0] FLAG_ACK = 8'h10;

	localparam logic [15:0] WINDOW_RESET = 16'hFFFF;

	// Flag byte classes resolved by the front end
	typedef enum logic [2:0] {
		CLS_OPEN,
		CLS_RST,
		CLS_SYN,
		CLS_ACK,
		CLS_PSH_ACK,
		CLS_FIN,
		CLS_OTHER
	} cls_t;

	typedef enum logic [2:0] {
		CS_CLOSED      = 3'd0,
		CS_LISTEN      = 3'd1,
		CS_SYN_RECVD   = 3'd2,
		CS_ESTABLISHED = 3'd3,
		CS_LAST_ACK    = 3'd4
	} conn_t;

	typedef enum logic [1:0] {
		STS_OK       = 2'd0,
		STS_ABORT    = 2'd1,
		STS_PEER_RST = 2'd2,
		STS_CLOSED   = 2'd3
	} sts_t;

	// Classified segment header passed from front to back
	typedef struct packed {
		cls_t        cls;
		logic        ack_zero;
		logic        plen_zero;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [15:0] plen;
		logic [31:0] iseq;
	} item_t;

	// One result beat
	typedef struct packed {
		logic        send_valid;
		logic [7:0]  flags;
		logic [31:0] seq;
		logic [31:0] ack;
		logic [15:0] window;
		logic [15:0] dlen;
		sts_t        status;
		logic        last;
	} res_t;

	// Back end status seen by the top level
	typedef struct packed {
		logic  take;
		logic  pend;
		conn_t conn;
	} bstat_t;

endpackage

`default_nettype wire

/* src/tcsf_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcsf_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire logic           action,
	input  wire logic [7:0]     seg_flags,
	input  wire logic [31:0]    seg_seq,
	input  wire logic [31:0]    seg_ack,
	input  wire logic [15:0]    payload_len,
	input  wire logic [31:0]    initial_seq,
	output logic                item_valid,
	input  wire logic           item_ready,
	output tcsf_pkg::item_t     item
);

	tcsf_pkg::item_t q_mem [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      cnt_q;
	tcsf_pkg::item_t new_item;
	tcsf_pkg::cls_t  cls;
	logic            wr_en;
	logic            rd_en;

	// Classify the flag byte; combinations are matched exactly
	always_comb begin
		cls = tcsf_pkg::CLS_OTHER;
		if (action) begin
			cls = tcsf_pkg::CLS_OPEN;
		end else if (seg_flags == tcsf_pkg::FLAG_RST ||
				seg_flags == (tcsf_pkg::FLAG_RST | tcsf_pkg::FLAG_ACK)) begin
			cls = tcsf_pkg::CLS_RST;
		end else if (seg_flags == tcsf_pkg::FLAG_SYN) begin
			cls = tcsf_pkg::CLS_SYN;
		end else if (seg_flags == tcsf_pkg::FLAG_ACK) begin
			cls = tcsf_pkg::CLS_ACK;
		end else if (seg_flags == (tcsf_pkg::FLAG_PSH | tcsf_pkg::FLAG_ACK)) begin
			cls = tcsf_pkg::CLS_PSH_ACK;
		end else if (seg_flags == tcsf_pkg::FLAG_FIN ||
				seg_flags == (tcsf_pkg::FLAG_FIN | tcsf_pkg::FLAG_ACK)) begin
			cls = tcsf_pkg::CLS_FIN;
		end
	end

	always_comb begin
		new_item.cls       = cls;
		new_item.ack_zero  = (seg_ack == 32'd0);
		new_item.plen_zero = (payload_len == 16'd0);
		new_item.seq       = seg_seq;
		new_item.ack       = seg_ack;
		new_item.plen      = payload_len;
		new_item.iseq      = initial_seq;
	end

	assign full       = (cnt_q == 2'd2);
	assign item_valid = (cnt_q != 2'd0);
	assign item       = q_mem[rd_ptr_q];
	assign wr_en      = push && !full;
	assign rd_en      = item_valid && item_ready;

	// Store the classified beat
	always_ff @(posedge clk) begin
		if (wr_en) begin
			q_mem[wr_ptr_q] <= new_item;
		end
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (rd_en) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

endmodule

`default_nettype wire

/* src/tcsf_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module tcsf_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            cfg_we,
	input  wire logic [15:0]     cfg_data,
	input  wire logic            item_valid,
	output logic                 item_ready,
	input  wire tcsf_pkg::item_t item,
	output logic                 empty,
	input  wire logic            pop,
	output tcsf_pkg::res_t       res,
	output tcsf_pkg::bstat_t     stat
);

	tcsf_pkg::conn_t state_q;
	tcsf_pkg::conn_t state_nxt;
	logic [31:0]     snd_q;
	logic [31:0]     snd_nxt;
	logic [31:0]     rcv_q;
	logic [31:0]     rcv_nxt;
	logic [15:0]     window_q;
	logic            pend_q;
	tcsf_pkg::res_t  fin_q;
	tcsf_pkg::res_t  res0;
	tcsf_pkg::res_t  res1;
	logic            two;
	logic            bad;
	logic            take;
	logic            match;
	logic [31:0]     rcv_inc;

	tcsf_pkg::res_t  o_mem [2];
	logic            owr_q;
	logic            ord_q;
	logic [1:0]      ocnt_q;
	logic            ofull;
	logic            owr_en;
	logic            ord_en;
	tcsf_pkg::res_t  owr_data;

	function automatic tcsf_pkg::res_t reply(input logic [7:0] flags, input logic [31:0] seq,
			input logic [31:0] ack, input logic [15:0] win, input logic [15:0] dlen,
			input logic last);
		tcsf_pkg::res_t r;
		r.send_valid = 1'b1;
		r.flags      = flags;
		r.seq        = seq;
		r.ack        = ack;
		r.window     = win;
		r.dlen       = dlen;
		r.status     = tcsf_pkg::STS_OK;
		r.last       = last;
		return r;
	endfunction

	function automatic tcsf_pkg::res_t note(input tcsf_pkg::sts_t status);
		tcsf_pkg::res_t r;
		r        = '0;
		r.status = status;
		r.last   = 1'b1;
		return r;
	endfunction

	assign ofull      = (ocnt_q == 2'd2);
	assign take       = item_valid && !pend_q && !ofull;
	assign item_ready = take;
	assign match      = (item.seq == rcv_q) && (item.ack == snd_q);
	assign rcv_inc    = rcv_q + 32'd1;

	// Execute one classified segment against the connection state
	always_comb begin
		state_nxt = state_q;
		snd_nxt   = snd_q;
		rcv_nxt   = rcv_q;
		res0      = note(tcsf_pkg::STS_OK);
		res1      = note(tcsf_pkg::STS_OK);
		two       = 1'b0;
		bad       = 1'b0;
		if (item.cls == tcsf_pkg::CLS_OPEN) begin
			state_nxt = tcsf_pkg::CS_LISTEN;
		end else if (item.cls == tcsf_pkg::CLS_RST) begin
			if (item.seq == rcv_q && item.ack_zero) begin
				state_nxt = tcsf_pkg::CS_CLOSED;
				res0      = note(tcsf_pkg::STS_PEER_RST);
			end else begin
				bad = 1'b1;
			end
		end else begin
			case (state_q)
				tcsf_pkg::CS_LISTEN: begin
					if (item.cls == tcsf_pkg::CLS_SYN && item.ack_zero && item.plen_zero) begin
						rcv_nxt   = item.seq;
						snd_nxt   = item.iseq;
						state_nxt = tcsf_pkg::CS_SYN_RECVD;
						res0      = reply(tcsf_pkg::FLAG_SYN | tcsf_pkg::FLAG_ACK, item.iseq,
							item.seq + 32'd1, window_q, 16'd0, 1'b1);
					end else begin
						bad = 1'b1;
					end
				end
				tcsf_pkg::CS_SYN_RECVD: begin
					if (item.cls == tcsf_pkg::CLS_ACK && item.seq == rcv_inc &&
							item.ack == snd_q + 32'd1 && item.plen_zero) begin
						snd_nxt   = snd_q + 32'd1;
						rcv_nxt   = rcv_inc;
						state_nxt = tcsf_pkg::CS_ESTABLISHED;
					end else begin
						bad = 1'b1;
					end
				end
				tcsf_pkg::CS_ESTABLISHED: begin
					if ((item.cls == tcsf_pkg::CLS_ACK || item.cls == tcsf_pkg::CLS_PSH_ACK) &&
							match) begin
						rcv_nxt = rcv_q + {16'd0, item.plen};
						res0    = reply(tcsf_pkg::FLAG_ACK, snd_q, rcv_q + {16'd0, item.plen},
							window_q, item.plen, 1'b1);
					end else if (item.cls == tcsf_pkg::CLS_FIN && match) begin
						rcv_nxt   = rcv_inc;
						snd_nxt   = snd_q + 32'd1;
						state_nxt = tcsf_pkg::CS_LAST_ACK;
						res0      = reply(tcsf_pkg::FLAG_ACK, snd_q, rcv_inc, window_q, 16'd0, 1'b0);
						res1      = reply(tcsf_pkg::FLAG_FIN, snd_q, rcv_inc, window_q, 16'd0, 1'b1);
						two       = 1'b1;
					end else begin
						bad = 1'b1;
					end
				end
				tcsf_pkg::CS_LAST_ACK: begin
					if (item.cls == tcsf_pkg::CLS_ACK && match) begin
						state_nxt = tcsf_pkg::CS_CLOSED;
						res0      = note(tcsf_pkg::STS_CLOSED);
					end else begin
						bad = 1'b1;
					end
				end
				default: begin
					bad = 1'b1;
				end
			endcase
		end
		// Abort: send RST and close
		if (bad) begin
			state_nxt   = tcsf_pkg::CS_CLOSED;
			snd_nxt     = snd_q;
			rcv_nxt     = rcv_q;
			two         = 1'b0;
			res0        = reply(tcsf_pkg::FLAG_RST, snd_q, rcv_q, window_q, 16'd0, 1'b1);
			res0.status = tcsf_pkg::STS_ABORT;
		end
	end

	// Connection state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tcsf_pkg::CS_LISTEN;
			snd_q   <= 32'd0;
			rcv_q   <= 32'd0;
		end else if (take) begin
			state_q <= state_nxt;
			snd_q   <= snd_nxt;
			rcv_q   <= rcv_nxt;
		end
	end

	// Window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= tcsf_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_data;
		end
	end

	// Hold the FIN beat until the result queue has room
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
		end else if (take) begin
			pend_q <= two;
		end else if (pend_q && !ofull) begin
			pend_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			fin_q <= res1;
		end
	end

	// Result queue
	assign owr_en   = take || (pend_q && !ofull);
	assign owr_data = pend_q ? fin_q : res0;
	assign empty    = (ocnt_q == 2'd0);
	assign ord_en   = pop && !empty;
	assign res      = o_mem[ord_q];

	always_ff @(posedge clk) begin
		if (owr_en) begin
			o_mem[owr_q] <= owr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owr_q  <= 1'b0;
			ord_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (owr_en) begin
				owr_q <= !owr_q;
			end
			if (ord_en) begin
				ord_q <= !ord_q;
			end
			if (owr_en && !ord_en) begin
				ocnt_q <= ocnt_q + 2'd1;
			end else if (ord_en && !owr_en) begin
				ocnt_q <= ocnt_q - 2'd1;
			end
		end
	end

	assign stat.take  = take;
	assign stat.pend  = pend_q;
	assign stat.conn  = state_q;

endmodule

`default_nettype wire

/* src/tcp_server_connection_fsm_top.sv */
// Server-side TCP connection state machine for a single connection.
// Input channel: a queue write port (push/full). Each beat is a passive-open
// command (action=1) or a received segment header; it is taken at a clock
// edge with push high and full low.
// Result channel: a queue read port (empty/pop). The oldest result sits on
// the result ports while empty is low and leaves on an edge with pop high.
// Every input gives one result, except an accepted FIN which gives two
// (ACK, then FIN); last marks the final result of an input.
// Configuration: cfg_valid/cfg_ready/cfg_data writes the advertised window;
// cfg_ready is always high.
// An input passes the input queue, then the executor writes its result into
// the two-entry result queue, the FIN beat after the ACK. Rate: one input
// and one result beat per cycle while no queue is full and no FIN is held.
// A two-entry queue between classifier and executor lets each side stall.
// Reset: state LISTEN, sequence numbers 0, window 65535, both queues empty.
// When the receiver stops popping, the result queue fills, the executor
// holds, and full rises once the two input entries are taken.
`timescale 1ns / 1ps
`default_nettype none

module tcp_server_connection_fsm_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	output logic             full,
	input  wire logic        action,
	input  wire logic [7:0]  seg_flags,
	input  wire logic [31:0] seg_seq,
	input  wire logic [31:0] seg_ack,
	input  wire logic [15:0] payload_len,
	input  wire logic [31:0] initial_seq,
	output logic             empty,
	input  wire logic        pop,
	output logic             send_valid,
	output logic [7:0]       out_flags,
	output logic [31:0]      out_seq,
	output logic [31:0]      out_ack,
	output logic [15:0]      out_window,
	output logic [15:0]      deliver_len,
	output logic [1:0]       status,
	output logic             last,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [15:0] cfg_data
);

	logic              item_valid;
	logic              item_ready;
	tcsf_pkg::item_t   item;
	tcsf_pkg::res_t    res;
	tcsf_pkg::bstat_t  stat;

	assign cfg_ready = 1'b1;

	tcsf_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.action      (action),
		.seg_flags   (seg_flags),
		.seg_seq     (seg_seq),
		.seg_ack     (seg_ack),
		.payload_len (payload_len),
		.initial_seq (initial_seq),
		.item_valid  (item_valid),
		.item_ready  (item_ready),
		.item        (item)
	);

	tcsf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.res        (res),
		.stat       (stat)
	);

	// Drive result ports from the head of the result queue
	assign send_valid  = res.send_valid;
	assign out_flags   = res.flags;
	assign out_seq     = res.seq;
	assign out_ack     = res.ack;
	assign out_window  = res.window;
	assign deliver_len = res.dlen;
	assign status      = res.status;
	assign last        = res.last;

	// Executor never takes a new segment while a FIN beat is held
	a_no_take_while_pend: assert property (@(posedge clk) disable iff (!arst_n)
		stat.take |-> !stat.pend)
		else $error("segment taken while FIN beat pending");

	// A held FIN beat only comes from entering the closing state
	a_pend_closing: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(stat.pend) |-> stat.conn == tcsf_pkg::CS_LAST_ACK)
		else $error("FIN beat pending outside the closing state");

	// Results without a reply carry an all-zero header
	a_zero_header: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !send_valid) |-> (out_flags == 8'd0 && out_seq == 32'd0 &&
			out_ack == 32'd0 && out_window == 16'd0))
		else $error("header fields set on a result without reply");

	// Non-ok status ends the input's results
	a_status_last: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status != tcsf_pkg::STS_OK) |-> last)
		else $error("non-ok status on a non-final result");

endmodule

`default_nettype wire
